// File: sv/swss_pkg.sv
// shared types and constants for the sliding window sum statistic
package swss_pkg;

  localparam int VALUE_W = 22;

  localparam logic [2:0] REG_SIZE   = 3'd0;
  localparam logic [2:0] REG_COUNT  = 3'd1;
  localparam logic [2:0] REG_OFFSET = 3'd2;
  localparam logic [2:0] REG_MODE   = 3'd3;

  localparam logic [2:0] MODE_AVG    = 3'd0;
  localparam logic [2:0] MODE_MIN    = 3'd1;
  localparam logic [2:0] MODE_MAX    = 3'd2;
  localparam logic [2:0] MODE_MAXMIN = 3'd3;
  localparam logic [2:0] MODE_MAXMAX = 3'd4;

  localparam logic [4:0] RST_SIZE   = 5'd4;
  localparam logic [3:0] RST_COUNT  = 4'd2;
  localparam logic [6:0] RST_OFFSET = 7'd2;
  localparam logic [2:0] RST_MODE   = MODE_AVG;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_DRAIN,
    ST_CALC,
    ST_DIV,
    ST_OUT
  } back_state_e;

endpackage

// File: sv/sliding_window_sum_statistic.sv
// top level of the sliding window sum statistic
// Takes one signed sample per word and returns, once window_offset +
// window_count*window_size words of a message have arrived, one statistic
// of the 2*window_count window sums per word (average, min, max, maxmin or
// maxmax by mode). The back part sweeps the history memory one sample a
// cycle through its single read port; the average then also runs the
// bit-serial divider over the width of the total of all sums.
// The front keeps taking words while the back works, through a two-entry job
// queue, until the queue fills or new words would overwrite history still in
// use. History needs no clearing pass after reset: a per-message fill count
// makes samples from before the message read as zero.
module sliding_window_sum_statistic
  import swss_pkg::*;
#(
  parameter int MAX_WINDOW_SIZE = 16,
  parameter int MAX_WINDOWS     = 8,
  parameter int MAX_OFFSET      = 64,
  parameter int SAMPLE_BITS     = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,  // sample
  input  logic                 s_axis_tuser,                // first
  input  logic                 s_axis_tlast,                // final_req
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [((VALUE_W+7)/8)*8-1:0] m_axis_tdata,        // value
  output logic                 m_axis_tlast,                // last_result
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [2:0]           cfg_index_i,
  input  logic [6:0]           cfg_data_i
);

  localparam int HIST  = 2 * (MAX_WINDOWS * MAX_WINDOW_SIZE + MAX_OFFSET);
  localparam int AW    = $clog2(HIST + 4);
  localparam int FW    = $clog2(HIST + 1);
  localparam int AGEW  = $clog2(HIST);
  localparam int SZW   = $clog2(MAX_WINDOW_SIZE + 1);
  localparam int CNW   = $clog2(MAX_WINDOWS + 1);
  localparam int OFW   = $clog2(MAX_OFFSET + 2);
  localparam int WNW   = $clog2(2 * MAX_WINDOWS + 1);
  localparam int SUMW  = SAMPLE_BITS + $clog2(MAX_WINDOW_SIZE);
  localparam int TW    = SUMW + $clog2(2 * MAX_WINDOWS);
  localparam int ODW   = ((VALUE_W + 7) / 8) * 8;
  localparam int JW    = AW + FW + 1;

  logic [4:0] size_q;
  logic [3:0] count_q;
  logic [6:0] offset_q;
  logic [2:0] mode_q;

  logic [SZW-1:0]  size_c;
  logic [CNW-1:0]  count_c;
  logic [OFW-1:0]  off_c;
  logic [FW-1:0]   look;
  logic [AGEW-1:0] base2;
  logic [FW-1:0]   span;

  logic          wr_en, push, pop, full, q_valid, busy;
  logic [AW-1:0] wr_addr, back_head, oldest;
  logic signed [SAMPLE_BITS-1:0] wr_data;
  logic [JW-1:0] job_in, job_out;
  logic signed [VALUE_W-1:0] value;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q   <= RST_SIZE;
      count_q  <= RST_COUNT;
      offset_q <= RST_OFFSET;
      mode_q   <= RST_MODE;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_SIZE:   size_q   <= cfg_data_i[4:0];
        REG_COUNT:  count_q  <= cfg_data_i[3:0];
        REG_OFFSET: offset_q <= cfg_data_i;
        REG_MODE:   mode_q   <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  // out-of-range register values saturate into the supported range
  always_comb begin
    if (size_q == 5'd0) begin
      size_c = SZW'(1);
    end else if (32'(size_q) > MAX_WINDOW_SIZE) begin
      size_c = SZW'(MAX_WINDOW_SIZE);
    end else begin
      size_c = SZW'(size_q);
    end
    if (count_q == 4'd0) begin
      count_c = CNW'(1);
    end else if (32'(count_q) > MAX_WINDOWS) begin
      count_c = CNW'(MAX_WINDOWS);
    end else begin
      count_c = CNW'(count_q);
    end
    if (32'(offset_q) > MAX_OFFSET) begin
      off_c = OFW'(MAX_OFFSET);
    end else begin
      off_c = OFW'(offset_q);
    end
  end

  assign span  = FW'(count_c) * FW'(size_c);
  assign look  = span + FW'(off_c);
  assign base2 = AGEW'(look + FW'(off_c));

  assign oldest = busy ? back_head : job_out[AW-1:0];

  swss_front #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .HIST        (HIST),
    .AW          (AW),
    .FW          (FW)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s_axis_tvalid),
    .ready_o   (s_axis_tready),
    .sample_i  (s_axis_tdata[SAMPLE_BITS-1:0]),
    .first_i   (s_axis_tuser),
    .final_i   (s_axis_tlast),
    .look_i    (look),
    .busy_i    (busy || q_valid),
    .oldest_i  (oldest),
    .full_i    (full),
    .wr_en_o   (wr_en),
    .wr_addr_o (wr_addr),
    .wr_data_o (wr_data),
    .push_o    (push),
    .job_o     (job_in)
  );

  swss_fifo #(
    .W (JW)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (job_in),
    .pop_i   (pop),
    .full_o  (full),
    .valid_o (q_valid),
    .data_o  (job_out)
  );

  swss_back #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .AW          (AW),
    .FW          (FW),
    .AGEW        (AGEW),
    .SZW         (SZW),
    .CNW         (CNW),
    .WNW         (WNW),
    .SUMW        (SUMW),
    .TW          (TW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_en_i     (wr_en),
    .wr_addr_i   (wr_addr),
    .wr_data_i   (wr_data),
    .job_valid_i (q_valid),
    .job_i       (job_out),
    .job_pop_o   (pop),
    .busy_o      (busy),
    .head_o      (back_head),
    .size_i      (size_c),
    .count_i     (count_c),
    .base2_i     (base2),
    .mode_i      (mode_q),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_value_o (value),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = ODW'(unsigned'(value));

endmodule

// File: sv/swss_fifo.sv
// two-entry job queue between the front and back parts
module swss_fifo #(
  parameter int W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  input  logic         pop_i,
  output logic         full_o,
  output logic         valid_o,
  output logic [W-1:0] data_o
);

  logic [W-1:0] slot_q [2];
  logic         rd_q, rd_d, wr_q, wr_d;
  logic [1:0]   cnt_q, cnt_d;

  always_comb begin
    rd_d  = rd_q;
    wr_d  = wr_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = ~wr_q;
    end
    if (pop_i) begin
      rd_d = ~rd_q;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= 1'b0;
      wr_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      rd_q  <= rd_d;
      wr_q  <= wr_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= data_i;
    end
  end

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = slot_q[rd_q];

endmodule

// File: sv/swss_front.sv
// front part: accepts words, tracks message fill and write pointer, queues jobs
module swss_front #(
  parameter int SAMPLE_BITS = 16,
  parameter int HIST        = 384,
  parameter int AW          = 9,
  parameter int FW          = 9
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic                          first_i,
  input  logic                          final_i,
  input  logic [FW-1:0]                 look_i,
  input  logic                          busy_i,
  input  logic [AW-1:0]                 oldest_i,
  input  logic                          full_i,
  output logic                          wr_en_o,
  output logic [AW-1:0]                 wr_addr_o,
  output logic signed [SAMPLE_BITS-1:0] wr_data_o,
  output logic                          push_o,
  output logic [AW+FW:0]                job_o
);

  localparam int SLACK = (2 ** AW) - HIST;

  logic [AW-1:0] head_q, head_d;
  logic [FW-1:0] fill_q, fill_d;
  logic          ended_q, ended_d;
  logic [AW-1:0] lag;
  logic          accept;

  assign lag     = head_q - oldest_i;
  assign ready_o = !full_i && (!busy_i || (32'(lag) < SLACK));
  assign accept  = valid_i && ready_o;

  always_comb begin
    head_d  = head_q;
    fill_d  = fill_q;
    ended_d = ended_q;
    if (accept) begin
      head_d  = head_q + AW'(1);
      ended_d = final_i;
      if (first_i || ended_q) begin
        fill_d = FW'(1);
      end else if (32'(fill_q) < HIST) begin
        fill_d = fill_q + FW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      fill_q  <= '0;
      ended_q <= 1'b0;
    end else begin
      head_q  <= head_d;
      fill_q  <= fill_d;
      ended_q <= ended_d;
    end
  end

  assign wr_en_o   = accept;
  assign wr_addr_o = head_d;
  assign wr_data_o = sample_i;
  assign push_o    = accept && (fill_d >= look_i);
  assign job_o     = {final_i, fill_d, head_d};

endmodule

// File: sv/swss_div.sv
// iterative divider with round-half-to-even on the magnitude
module swss_div #(
  parameter int TW = 24,
  parameter int NW = 5
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [TW-1:0]        mag_i,
  input  logic                 neg_i,
  input  logic [NW-1:0]        den_i,
  output logic                 done_o,
  output logic signed [TW:0]   quo_o
);

  localparam int CW = $clog2(TW + 1);

  logic          run_q, rnd_q, done_q;
  logic [CW-1:0] cnt_q;
  logic [NW-1:0] rem_q, den_q;
  logic [TW-1:0] quo_q;
  logic          neg_q;
  logic signed [TW:0] res_q;
  logic [NW:0]   r2, twor;
  logic          ge, up;
  logic [TW:0]   qmag;

  assign r2   = {rem_q, quo_q[TW-1]};
  assign ge   = (r2 >= {1'b0, den_q});
  assign twor = {rem_q, 1'b0};
  assign up   = (twor > {1'b0, den_q}) || ((twor == {1'b0, den_q}) && quo_q[0]);
  assign qmag = {1'b0, quo_q} + (TW + 1)'(up);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      rnd_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CW'(TW);
      end else if (run_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          run_q <= 1'b0;
          rnd_q <= 1'b1;
        end
      end else if (rnd_q) begin
        rnd_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= mag_i;
      rem_q <= '0;
      den_q <= den_i;
      neg_q <= neg_i;
    end else if (run_q) begin
      rem_q <= ge ? NW'(r2 - {1'b0, den_q}) : NW'(r2);
      quo_q <= {quo_q[TW-2:0], ge};
    end else if (rnd_q) begin
      res_q <= neg_q ? -$signed(qmag) : $signed(qmag);
    end
  end

  assign done_o = done_q;
  assign quo_o  = res_q;

endmodule

// File: sv/swss_back.sv
// back part: history memory, window sweep, reduction and result register
module swss_back
  import swss_pkg::*;
#(
  parameter int SAMPLE_BITS = 16,
  parameter int AW          = 9,
  parameter int FW          = 9,
  parameter int AGEW        = 9,
  parameter int SZW         = 5,
  parameter int CNW         = 4,
  parameter int WNW         = 5,
  parameter int SUMW        = 20,
  parameter int TW          = 24
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           wr_en_i,
  input  logic [AW-1:0]                  wr_addr_i,
  input  logic signed [SAMPLE_BITS-1:0]  wr_data_i,
  input  logic                           job_valid_i,
  input  logic [AW+FW:0]                 job_i,
  output logic                           job_pop_o,
  output logic                           busy_o,
  output logic [AW-1:0]                  head_o,
  input  logic [SZW-1:0]                 size_i,
  input  logic [CNW-1:0]                 count_i,
  input  logic [AGEW-1:0]                base2_i,
  input  logic [2:0]                     mode_i,
  input  logic                           out_ready_i,
  output logic                           out_valid_o,
  output logic signed [VALUE_W-1:0]      out_value_o,
  output logic                           out_last_o
);

  logic signed [SAMPLE_BITS-1:0] hist_mem [2 ** AW];
  logic signed [SAMPLE_BITS-1:0] rd_data_q;

  back_state_e   state_q, state_d;
  logic [AW-1:0] head_q;
  logic [FW-1:0] fill_q;
  logic          fin_q;
  logic [AGEW-1:0] age_q;
  logic [SZW-1:0]  tap_q;
  logic [WNW-1:0]  win_q;
  logic [AW-1:0]   rd_addr;
  logic            tap_end, lead_side, last_win;
  logic [WNW-1:0]  cnt2;

  logic p_valid_q, p_in_q, p_end_q, p_lead_q;
  logic signed [SUMW-1:0] acc_q, add, accs;
  logic signed [SUMW-1:0] minl_q, maxl_q, mint_q, maxt_q;
  logic                   lead_seen_q, trail_seen_q;
  logic signed [TW-1:0]   total_q;

  logic signed [SUMW-1:0] lo_min, hi_min, hi_max, lo_max;
  logic signed [VALUE_W-1:0] res_q, calc_val;
  logic                   div_start, div_done;
  logic signed [TW:0]     div_quo;
  logic [TW-1:0]          mag;
  logic                   out_valid_q;
  logic signed [VALUE_W-1:0] out_value_q;
  logic                   out_last_q;
  logic                   out_free;

  // history memory: one write port from the front, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      hist_mem[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= hist_mem[rd_addr];
  end

  assign rd_addr   = head_q - AW'(age_q);
  assign cnt2      = WNW'({count_i, 1'b0});
  assign tap_end   = (tap_q == size_i - SZW'(1));
  assign lead_side = (win_q < WNW'(count_i));
  assign last_win  = (win_q == cnt2 - WNW'(1));
  assign out_free  = !out_valid_q || out_ready_i;

  // statistic selection
  always_comb begin
    lo_min = (mint_q < minl_q) ? mint_q : minl_q;
    hi_min = (mint_q > minl_q) ? mint_q : minl_q;
    hi_max = (maxt_q > maxl_q) ? maxt_q : maxl_q;
    lo_max = (maxt_q < maxl_q) ? maxt_q : maxl_q;
    case (mode_i)
      MODE_MIN:    calc_val = VALUE_W'(lo_min);
      MODE_MAX:    calc_val = VALUE_W'(hi_max);
      MODE_MAXMIN: calc_val = VALUE_W'((SUMW + 1)'(hi_min) + (SUMW + 1)'(lo_max));
      MODE_MAXMAX: calc_val = VALUE_W'((SUMW + 1)'(hi_min) + (SUMW + 1)'(hi_max));
      default:     calc_val = '0;
    endcase
  end

  assign mag = total_q[TW-1] ? TW'(-total_q) : TW'(total_q);

  always_comb begin
    state_d   = state_q;
    job_pop_o = 1'b0;
    div_start = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (job_valid_i) begin
          job_pop_o = 1'b1;
          state_d   = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        if (tap_end && last_win) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: state_d = ST_CALC;
      ST_CALC: begin
        if (mode_i == MODE_MIN || mode_i == MODE_MAX || mode_i == MODE_MAXMIN ||
            mode_i == MODE_MAXMAX) begin
          state_d = ST_OUT;
        end else begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      p_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      p_valid_q <= (state_q == ST_SWEEP);
      if (state_q == ST_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // sweep counters and first pipeline stage
  always_ff @(posedge clk_i) begin
    p_in_q   <= (FW'(age_q) < fill_q);
    p_end_q  <= tap_end;
    p_lead_q <= lead_side;
    if (state_q == ST_IDLE) begin
      head_q <= job_i[AW-1:0];
      fill_q <= job_i[AW+FW-1:AW];
      fin_q  <= job_i[AW+FW];
      age_q  <= '0;
      tap_q  <= '0;
      win_q  <= '0;
    end else if (state_q == ST_SWEEP) begin
      if (tap_end) begin
        tap_q <= '0;
        win_q <= win_q + WNW'(1);
        // leading windows done: jump over the guard gaps to the trailing side
        age_q <= (win_q + WNW'(1) == WNW'(count_i)) ? base2_i : age_q + AGEW'(1);
      end else begin
        tap_q <= tap_q + SZW'(1);
        age_q <= age_q + AGEW'(1);
      end
    end
  end

  assign add  = p_in_q ? SUMW'(rd_data_q) : '0;
  assign accs = acc_q + add;

  // accumulation and running reduction
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE) begin
      acc_q        <= '0;
      total_q      <= '0;
      lead_seen_q  <= 1'b0;
      trail_seen_q <= 1'b0;
    end else if (p_valid_q) begin
      if (p_end_q) begin
        acc_q   <= '0;
        total_q <= total_q + TW'(accs);
        if (p_lead_q) begin
          lead_seen_q <= 1'b1;
          if (!lead_seen_q || accs < minl_q) minl_q <= accs;
          if (!lead_seen_q || accs > maxl_q) maxl_q <= accs;
        end else begin
          trail_seen_q <= 1'b1;
          if (!trail_seen_q || accs < mint_q) mint_q <= accs;
          if (!trail_seen_q || accs > maxt_q) maxt_q <= accs;
        end
      end else begin
        acc_q <= accs;
      end
    end
    if (state_q == ST_CALC) begin
      res_q <= calc_val;
    end else if (state_q == ST_DIV && div_done) begin
      res_q <= VALUE_W'(div_quo);
    end
    if (state_q == ST_OUT && out_free) begin
      out_value_q <= res_q;
      out_last_q  <= fin_q;
    end
  end

  swss_div #(
    .TW (TW),
    .NW (WNW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .mag_i   (mag),
    .neg_i   (total_q[TW-1]),
    .den_i   (cnt2),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  assign busy_o      = (state_q != ST_IDLE);
  assign head_o      = head_q;
  assign out_valid_o = out_valid_q;
  assign out_value_o = out_value_q;
  assign out_last_o  = out_last_q;

`ifndef SYNTHESIS
  a_win_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SWEEP |-> win_q < cnt2)
    else $error("window index beyond window count");
  a_pipe_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p_valid_q |-> $past(state_q == ST_SWEEP))
    else $error("read pipeline valid outside sweep");
  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DIV)
    else $error("divider finished outside divide state");
`endif

endmodule
